// ----- rtl/triangle_unit_normal_core_defines.svh -----
// Assertion macros for the triangle unit normal core
`ifndef TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TUN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TUN_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TUN_ASSERT(label, clk, rst_n, prop, msg)
`define TUN_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ----- rtl/tun_pkg.sv -----
// Package: widths, constants and types of the triangle unit normal core
`default_nettype none
package tun_pkg;
    localparam int CoordWidth = 32;
    localparam int EdgeWidth  = CoordWidth + 1;
    localparam int FracOne    = 30;
    localparam int OutWidth   = 32;
    localparam int SqrtBits   = 32;   // result bits of the root
    localparam int QuotBits   = 32;   // quotient bits produced
    localparam int Stages     = SqrtBits + QuotBits + 7;

    typedef logic signed [CoordWidth-1:0] coord_t;
    typedef logic signed [OutWidth-1:0]   comp_t;

    typedef struct packed {
        coord_t ax; coord_t ay; coord_t az;
        coord_t bx; coord_t by; coord_t bz;
        coord_t cx; coord_t cy; coord_t cz;
    } tri_t;

    typedef struct packed {
        comp_t nx; comp_t ny; comp_t nz;
        logic  degenerate;
    } nrm_t;

    // pipeline control from top to pipe: one advance shared by all stages
    typedef struct packed {
        logic advance;
    } pipe_ctrl_t;
endpackage
`default_nettype wire

// ----- rtl/tun_if.sv -----
// Valid/ready channel interfaces of the triangle unit normal core
`default_nettype none
interface tun_tri_if (input wire logic clk);
    logic          valid;
    logic          ready;
    tun_pkg::tri_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tun_nrm_if (input wire logic clk);
    logic          valid;
    logic          ready;
    tun_pkg::nrm_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/triangle_unit_normal_core.sv -----
// Top level of the triangle unit normal core
// Pipeline: 7 setup stages, 32 root stages and 32 division stages; the output
//   is the last stage, with no extra register behind it.
// Throughput: one triangle per cycle; the whole pipeline stalls while the
//   result at the end is not taken, and holds every item in place.
// Reset: rst_n clears all stage valid bits asynchronously; data needs no reset.
`default_nettype none
`include "triangle_unit_normal_core_defines.svh"
module triangle_unit_normal_core (
    input wire logic  clk,
    input wire logic  rst_n,
    tun_tri_if.sink   tri_in,
    tun_nrm_if.source nrm_out
);
    tun_pkg::pipe_ctrl_t ctrl;
    logic                pv;
    tun_pkg::nrm_t       pd;

    // advance when the last stage is empty or being taken
    assign ctrl.advance      = !pv || nrm_out.ready;
    assign tri_in.ready      = ctrl.advance;

    tun_pipe u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .in_valid (tri_in.valid),
        .in_data  (tri_in.data),
        .out_valid(pv),
        .out_data (pd)
    );

    assign nrm_out.valid = pv;
    assign nrm_out.data  = pd;

    `TUN_ASSERT(a_stall, clk, rst_n, (nrm_out.valid && !nrm_out.ready) |-> !tri_in.ready, "accepted while stalled")
    `TUN_ASSERT(a_deg_zero, clk, rst_n, (nrm_out.valid && nrm_out.data.degenerate) |-> (nrm_out.data.nx == 0 && nrm_out.data.ny == 0 && nrm_out.data.nz == 0), "degenerate not zero")
    `TUN_ASSERT_RST(a_reset, clk, !rst_n |-> !nrm_out.valid, "result valid during reset")
endmodule
`default_nettype wire

// ----- rtl/tun_pipe.sv -----
// Pipelined datapath: edges, cross product, block scaling, root and division
`default_nettype none
`include "triangle_unit_normal_core_defines.svh"
module tun_pipe (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tun_pkg::pipe_ctrl_t ctrl,
    input  wire logic               in_valid,
    input  wire tun_pkg::tri_t      in_data,
    output logic                    out_valid,
    output tun_pkg::nrm_t           out_data
);
    localparam int EW = tun_pkg::EdgeWidth;
    localparam int SB = tun_pkg::SqrtBits;
    localparam int QB = tun_pkg::QuotBits;

    // ---------------- stage 1: edges and their magnitudes
    logic               v1_reg;
    logic [EW-1:0]      emag1_reg [6];
    logic [5:0]         eneg1_reg;
    logic signed [EW-1:0] e_c [6];

    always_comb
    begin
        e_c[0] = EW'(in_data.bx) - EW'(in_data.ax);
        e_c[1] = EW'(in_data.by) - EW'(in_data.ay);
        e_c[2] = EW'(in_data.bz) - EW'(in_data.az);
        e_c[3] = EW'(in_data.cx) - EW'(in_data.ax);
        e_c[4] = EW'(in_data.cy) - EW'(in_data.ay);
        e_c[5] = EW'(in_data.cz) - EW'(in_data.az);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (ctrl.advance)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int i = 0; i < 6; i++)
            begin
                eneg1_reg[i] <= e_c[i][EW-1];
                emag1_reg[i] <= e_c[i][EW-1] ? EW'(-e_c[i]) : EW'(e_c[i]);
            end
        end
    end

    // ---------------- stage 2: common right shift to fit 30 bits
    logic          v2_reg;
    logic [29:0]   em2_reg [6];
    logic [5:0]    eneg2_reg;
    logic [EW-1:0] or_c;
    logic [2:0]    sh_c;

    always_comb
    begin
        or_c = '0;
        for (int i = 0; i < 6; i++)
            or_c = or_c | emag1_reg[i];
        sh_c = or_c[32] ? 3'd3 : or_c[31] ? 3'd2 : or_c[30] ? 3'd1 : 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (ctrl.advance)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            eneg2_reg <= eneg1_reg;
            for (int i = 0; i < 6; i++)
                em2_reg[i] <= 30'(emag1_reg[i] >> sh_c);
        end
    end

    // ---------------- stage 3: six products of the cross product
    logic                v3_reg;
    logic signed [60:0]  pr3_reg [6];
    logic signed [30:0]  es [6];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
            es[i] = eneg2_reg[i] ? -$signed({1'b0, em2_reg[i]})
                                 : $signed({1'b0, em2_reg[i]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (ctrl.advance)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            pr3_reg[0] <= 61'(es[1]) * 61'(es[5]);
            pr3_reg[1] <= 61'(es[2]) * 61'(es[4]);
            pr3_reg[2] <= 61'(es[2]) * 61'(es[3]);
            pr3_reg[3] <= 61'(es[0]) * 61'(es[5]);
            pr3_reg[4] <= 61'(es[0]) * 61'(es[4]);
            pr3_reg[5] <= 61'(es[1]) * 61'(es[3]);
        end
    end

    // ---------------- stage 4: differences, magnitudes, signs
    logic                v4_reg;
    logic [60:0]         cm4_reg [3];
    logic [2:0]          cneg4_reg;
    logic signed [61:0]  cd [3];

    always_comb
    begin
        cd[0] = 62'(pr3_reg[0]) - 62'(pr3_reg[1]);
        cd[1] = 62'(pr3_reg[2]) - 62'(pr3_reg[3]);
        cd[2] = 62'(pr3_reg[4]) - 62'(pr3_reg[5]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (ctrl.advance)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cneg4_reg[i] <= cd[i][61];
                cm4_reg[i]   <= 61'(cd[i][61] ? -cd[i] : cd[i]);
            end
        end
    end

    // ---------------- stage 5: leading one of the largest magnitude
    logic          v5_reg;
    logic [60:0]   cm5_reg [3];
    logic [2:0]    cneg5_reg;
    logic [5:0]    nb5_reg;
    logic          deg5_reg;
    logic [60:0]   cor_c;
    logic [5:0]    nb_c;

    always_comb
    begin
        cor_c = cm4_reg[0] | cm4_reg[1] | cm4_reg[2];
        nb_c  = '0;
        for (int i = 0; i < 61; i++)
            if (cor_c[i])
                nb_c = 6'(i + 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (ctrl.advance)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            cm5_reg   <= cm4_reg;
            cneg5_reg <= cneg4_reg;
            nb5_reg   <= nb_c;
            deg5_reg  <= (cor_c == '0);
        end
    end

    // ---------------- stage 6: normalise to [2^30, 2^31)
    logic          v6_reg;
    logic [30:0]   m6_reg [3];
    logic [2:0]    cneg6_reg;
    logic          deg6_reg;
    logic [91:0]   wide_c [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            wide_c[i] = ({cm5_reg[i], 31'd0}) >> nb5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (ctrl.advance)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            cneg6_reg <= cneg5_reg;
            deg6_reg  <= deg5_reg;
            for (int i = 0; i < 3; i++)
                m6_reg[i] <= 31'(wide_c[i]);
        end
    end

    // ---------------- stage 7: sum of squares
    logic          v7_reg;
    logic [30:0]   m7_reg [3];
    logic [63:0]   sq7_reg;
    logic [2:0]    cneg7_reg;
    logic          deg7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (ctrl.advance)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            m7_reg    <= m6_reg;
            cneg7_reg <= cneg6_reg;
            deg7_reg  <= deg6_reg;
            sq7_reg   <= 64'(m6_reg[0]) * 64'(m6_reg[0]) + 64'(m6_reg[1]) * 64'(m6_reg[1])
                       + 64'(m6_reg[2]) * 64'(m6_reg[2]);
        end
    end

    // ---------------- root: one result bit a stage, restoring
    logic          rv_reg   [SB+1];
    logic [63:0]   rrem_reg [SB+1];
    logic [SB-1:0] rroot_reg[SB+1];
    logic [30:0]   rm_reg   [SB+1][3];
    logic [2:0]    rneg_reg [SB+1];
    logic          rdeg_reg [SB+1];

    always_comb
    begin
        rv_reg[0]    = v7_reg;
        rrem_reg[0]  = sq7_reg;
        rroot_reg[0] = '0;
        rm_reg[0]    = m7_reg;
        rneg_reg[0]  = cneg7_reg;
        rdeg_reg[0]  = deg7_reg;
    end

    for (genvar k = 0; k < SB; k++)
    begin : g_root
        localparam int B = SB - 1 - k;
        logic [65:0] trial;
        logic [65:0] cand;
        always_comb
        begin
            cand  = (66'(rroot_reg[k]) << (B + 1)) + (66'd1 << (2 * B));
            trial = 66'(rrem_reg[k]) - cand;
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rv_reg[k+1] <= 1'b0;
            else if (ctrl.advance)
                rv_reg[k+1] <= rv_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (ctrl.advance)
            begin
                rm_reg[k+1]   <= rm_reg[k];
                rneg_reg[k+1] <= rneg_reg[k];
                rdeg_reg[k+1] <= rdeg_reg[k];
                if (!trial[65])
                begin
                    rrem_reg[k+1]  <= 64'(trial);
                    rroot_reg[k+1] <= rroot_reg[k] | (SB'(1) << B);
                end
                else
                begin
                    rrem_reg[k+1]  <= rrem_reg[k];
                    rroot_reg[k+1] <= rroot_reg[k];
                end
            end
        end
    end

    // ---------------- division: three lanes, one quotient bit a stage
    // numerator m*2^30 + L/2 fits 62 bits; quotient at most 2^30
    logic          dv_reg   [QB+1];
    logic [SB-1:0] dl_reg   [QB+1];
    logic [61:0]   dn_reg   [QB+1][3];
    logic [31:0]   dr_reg   [QB+1][3];
    logic [QB-1:0] dq_reg   [QB+1][3];
    logic [2:0]    dneg_reg [QB+1];
    logic          ddeg_reg [QB+1];

    always_comb
    begin
        dv_reg[0]   = rv_reg[SB];
        dl_reg[0]   = rroot_reg[SB];
        dneg_reg[0] = rneg_reg[SB];
        ddeg_reg[0] = rdeg_reg[SB];
        for (int i = 0; i < 3; i++)
        begin
            dn_reg[0][i] = {rm_reg[SB][i], 30'd0} + 62'(rroot_reg[SB] >> 1);
            dr_reg[0][i] = 32'(dn_reg[0][i] >> QB);
            dq_reg[0][i] = '0;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        localparam int B = QB - 1 - k;
        logic [32:0] rs [3];
        logic [33:0] df [3];
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rs[i] = {dr_reg[k][i], dn_reg[k][i][B]};
                df[i] = 34'(rs[i]) - 34'(dl_reg[k]);
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else if (ctrl.advance)
                dv_reg[k+1] <= dv_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (ctrl.advance)
            begin
                dl_reg[k+1]   <= dl_reg[k];
                dneg_reg[k+1] <= dneg_reg[k];
                ddeg_reg[k+1] <= ddeg_reg[k];
                dn_reg[k+1]   <= dn_reg[k];
                for (int i = 0; i < 3; i++)
                begin
                    if (!df[i][33])
                    begin
                        dr_reg[k+1][i] <= 32'(df[i]);
                        dq_reg[k+1][i] <= dq_reg[k][i] | (QB'(1) << B);
                    end
                    else
                    begin
                        dr_reg[k+1][i] <= 32'(rs[i]);
                        dq_reg[k+1][i] <= dq_reg[k][i];
                    end
                end
            end
        end
    end

    // ---------------- final: signs and degenerate override
    always_comb
    begin
        out_valid           = dv_reg[QB];
        out_data.degenerate = ddeg_reg[QB];
        out_data.nx = ddeg_reg[QB] ? '0 : dneg_reg[QB][0] ? -$signed(dq_reg[QB][0])
                                                          : $signed(dq_reg[QB][0]);
        out_data.ny = ddeg_reg[QB] ? '0 : dneg_reg[QB][1] ? -$signed(dq_reg[QB][1])
                                                          : $signed(dq_reg[QB][1]);
        out_data.nz = ddeg_reg[QB] ? '0 : dneg_reg[QB][2] ? -$signed(dq_reg[QB][2])
                                                          : $signed(dq_reg[QB][2]);
    end

    `TUN_ASSERT(a_root_min, clk, rst_n,
        (rv_reg[SB] && !rdeg_reg[SB]) |-> (rroot_reg[SB][31:30] != 2'b00), "root below 2^30")
    `TUN_ASSERT(a_norm_range, clk, rst_n, (v6_reg && !deg6_reg) |-> (m6_reg[0][30] || m6_reg[1][30] || m6_reg[2][30]), "normalisation lost leading one")
    `TUN_ASSERT(a_quot_range, clk, rst_n,
        (dv_reg[QB] && !ddeg_reg[QB]) |-> (dq_reg[QB][0] <= 32'h4000_0000), "quotient above one")
    `TUN_ASSERT(a_hold, clk, rst_n, (!ctrl.advance && out_valid) |=> out_valid, "stalled item lost")
endmodule
`default_nettype wire

// ----- test/triangle_unit_normal_core_tb.sv -----
// Testbench: random and directed triangles checked against a face normal predictor
`timescale 1ns / 100ps
`default_nettype none
module triangle_unit_normal_core_tb;
    localparam int NumRandom  = 750;
    localparam int WatchLimit = 4000;
    localparam int Latency    = tun_pkg::Stages;

    logic clk;
    logic rst_n;

    tun_tri_if tri_in (.clk(clk));
    tun_nrm_if nrm_out (.clk(clk));

    triangle_unit_normal_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tri_in  (tri_in.sink),
        .nrm_out (nrm_out.source)
    );

    tun_pkg::tri_t pending_tris[$];
    tun_pkg::nrm_t expected_normals[$];
    int     mismatches;
    int     idle_count;
    int     send_gap;
    int     recv_gap;
    bit     stimulus_done;
    bit     hold_off;
    bit     sender_pause;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic longint unsigned mag_of(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned root_of(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'h4000_0000_0000_0000;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic tun_pkg::nrm_t face_normal(tun_pkg::tri_t t);
        longint          p[9];
        longint          e[6];
        longint          c[3];
        longint unsigned m[3];
        longint unsigned peak;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        int              s;
        int              nb;
        tun_pkg::nrm_t   r;
        p = '{longint'(t.ax), longint'(t.ay), longint'(t.az),
              longint'(t.bx), longint'(t.by), longint'(t.bz),
              longint'(t.cx), longint'(t.cy), longint'(t.cz)};
        for (int i = 0; i < 3; i++)
        begin
            e[i]     = p[3+i] - p[i];
            e[3+i]   = p[6+i] - p[i];
        end
        peak = 0;
        for (int i = 0; i < 6; i++)
            if (mag_of(e[i]) > peak)
                peak = mag_of(e[i]);
        s = 0;
        while ((peak >> s) >= (64'd1 << 30))
            s++;
        for (int i = 0; i < 6; i++)
            e[i] = (e[i] < 0) ? -longint'(mag_of(e[i]) >> s) : longint'(mag_of(e[i]) >> s);
        c[0] = e[1] * e[5] - e[2] * e[4];
        c[1] = e[2] * e[3] - e[0] * e[5];
        c[2] = e[0] * e[4] - e[1] * e[3];
        r = '0;
        if (c[0] == 0 && c[1] == 0 && c[2] == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        peak = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = mag_of(c[i]);
            if (m[i] > peak)
                peak = m[i];
        end
        nb = $clog2(peak + 1);
        for (int i = 0; i < 3; i++)
            m[i] = (nb > 31) ? (m[i] >> (nb - 31)) : (m[i] << (31 - nb));
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = root_of(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << tun_pkg::FracOne) + (len >> 1)) / len;
            if (c[i] < 0)
                q = 64'd0 - q;
            case (i)
                0: r.nx = tun_pkg::comp_t'(q[31:0]);
                1: r.ny = tun_pkg::comp_t'(q[31:0]);
                default: r.nz = tun_pkg::comp_t'(q[31:0]);
            endcase
        end
        return r;
    endfunction

    // Pick a coordinate: extremes, small values, mid-range multiples of 256, or full range
    function automatic tun_pkg::coord_t pick_coord();
        case ($urandom_range(0, 7))
            0: return tun_pkg::coord_t'(32'h8000_0000);
            1: return tun_pkg::coord_t'(32'h7fff_ffff);
            2: return tun_pkg::coord_t'($urandom_range(0, 64) - 32);
            3, 4: return tun_pkg::coord_t'(($urandom_range(0, 20'hfffff) - 20'h80000) << 8);
            default: return tun_pkg::coord_t'($urandom);
        endcase
    endfunction

    function automatic tun_pkg::tri_t random_tri();
        tun_pkg::tri_t t;
        t = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
             pick_coord(), pick_coord(), pick_coord(), pick_coord()};
        // make some degenerate by repeated vertices; some others share an x coordinate
        case ($urandom_range(0, 15))
            0: t.cx = t.ax;
            1:
            begin
                t.bx = t.ax; t.by = t.ay; t.bz = t.az;
            end
            2:
            begin
                t.cx = t.bx; t.cy = t.by; t.cz = t.bz;
            end
            default: ;
        endcase
        return t;
    endfunction

    function automatic tun_pkg::tri_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                               int cx, int cy, int cz);
        return {tun_pkg::coord_t'(ax), tun_pkg::coord_t'(ay), tun_pkg::coord_t'(az),
                tun_pkg::coord_t'(bx), tun_pkg::coord_t'(by), tun_pkg::coord_t'(bz),
                tun_pkg::coord_t'(cx), tun_pkg::coord_t'(cy), tun_pkg::coord_t'(cz)};
    endfunction

    // Append a triangle to the pending queue
    task automatic queue_tri(input tun_pkg::tri_t t);
        pending_tris = {pending_tris, t};
    endtask

    initial
    begin
        int one;
        int mn;
        int mx;
        one = 32'h0001_0000;
        mn  = 32'h8000_0000;
        mx  = 32'h7fff_ffff;
        queue_tri(make_tri(0, 0, 0, one, 0, 0, 0, one, 0));
        queue_tri(make_tri(0, 0, 0, 0, one, 0, one, 0, 0));
        queue_tri(make_tri(0, 0, 0, 0, 0, one, one, 0, 0));
        queue_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_tri(make_tri(1, 2, 3, 1, 2, 3, 7, 8, 9));
        queue_tri(make_tri(0, 0, 0, one, one, one, 2*one, 2*one, 2*one));
        queue_tri(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn));
        queue_tri(make_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx));
        queue_tri(make_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx));
        queue_tri(make_tri(mx, mn, mx, mn, mx, mn, mx, mx, mn));
        queue_tri(make_tri(mn, mn, mn, mx, mx, mx, mx, mx, mn));
        queue_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        queue_tri(make_tri(0, 0, 0, 1, 0, 0, 2, 0, 0));
        queue_tri(make_tri(-1, -1, -1, 0, 0, 0, 1, 1, 2));
        queue_tri(make_tri(0, 0, 0, mx, 1, 0, 1, mx, 0));
        queue_tri(make_tri(0, 0, 0, mn, 0, 1, 0, mn, 1));
        queue_tri(make_tri(0, 0, 0, 3, 4, 0, -4, 3, 5));
        queue_tri(make_tri(mx, 0, 0, mn, 0, 0, 0, 0, mx));
        for (int i = 0; i < NumRandom; i++)
            queue_tri(random_tri());
    end

    // Sender: one item at a time from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_in.valid <= 1'b0;
            tri_in.data  <= '0;
            send_gap     <= 0;
            sender_pause <= 1'b0;
        end
        else
        begin
            if (tri_in.valid && tri_in.ready)
            begin
                expected_normals = {expected_normals, face_normal(tri_in.data)};
                if (pending_tris.size() == 400)
                    sender_pause <= 1'b1;
            end
            if (sender_pause && !(tri_in.valid && tri_in.ready) &&
                expected_normals.size() == 0)
                sender_pause <= 1'b0;
            if (!tri_in.valid || tri_in.ready)
            begin
                if (send_gap > 0 || sender_pause || pending_tris.size() == 0 ||
                    (tri_in.valid && pending_tris.size() == 400))
                begin
                    tri_in.valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap <= send_gap - 1;
                end
                else
                begin
                    tri_in.valid <= 1'b1;
                    tri_in.data  <= pending_tris.pop_front();
                    send_gap     <= (pending_tris.size() % 200 < 60) ? 0
                                                                   : $urandom_range(0, 4);
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off to fill the pipeline
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nrm_out.ready <= 1'b0;
            recv_gap      <= 0;
            mismatches    <= 0;
            hold_off      <= 1'b0;
        end
        else
        begin
            if (nrm_out.valid && nrm_out.ready)
            begin
                if (expected_normals.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected normal %p", nrm_out.data);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    tun_pkg::nrm_t exp_n;
                    exp_n = expected_normals.pop_front();
                    if (exp_n.nx !== nrm_out.data.nx || exp_n.ny !== nrm_out.data.ny ||
                        exp_n.nz !== nrm_out.data.nz ||
                        exp_n.degenerate !== nrm_out.data.degenerate)
                    begin
                        if (mismatches < 10)
                            $display({"normal mismatch: expected %0d %0d %0d deg %0b, ",
                                      "got %0d %0d %0d deg %0b"},
                                     exp_n.nx, exp_n.ny, exp_n.nz, exp_n.degenerate,
                                     nrm_out.data.nx, nrm_out.data.ny, nrm_out.data.nz,
                                     nrm_out.data.degenerate);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (!hold_off && pending_tris.size() <= 600)
            begin
                hold_off      <= 1'b1;
                recv_gap      <= 200;
                nrm_out.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap      <= recv_gap - 1;
                nrm_out.ready <= 1'b0;
            end
            else if (nrm_out.valid && nrm_out.ready || !nrm_out.ready)
            begin
                if (!nrm_out.ready || (pending_tris.size() % 250) < 80)
                    nrm_out.ready <= 1'b1;
                else
                begin
                    nrm_out.ready <= 1'b0;
                    recv_gap      <= $urandom_range(0, 4);
                end
            end
        end
    end

    // Watchdog: cycles with no item accepted on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_count <= 0;
        else if ((tri_in.valid && tri_in.ready) || (nrm_out.valid && nrm_out.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        fork
            begin
                wait (pending_tris.size() == 0 && !tri_in.valid &&
                      expected_normals.size() == 0);
                repeat (Latency + 20) @(posedge clk);
                if (mismatches == 0 && expected_normals.size() == 0)
                    $display("triangle_unit_normal_core test passed");
                else
                    $display("triangle_unit_normal_core test failed");
                $finish;
            end
            begin
                wait (idle_count >= WatchLimit);
                $display("triangle_unit_normal_core test failed");
                $finish;
            end
        join
    end
endmodule
`default_nettype wire
